// ===== design/detection_head_decoder_top_assert.svh =====
// Assertion macros for the detection head decoder.
`ifndef DETECTION_HEAD_DECODER_TOP_ASSERT_SVH
`define DETECTION_HEAD_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DHD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DHD_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define DHD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define DHD_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// ===== design/dhd_pkg.sv =====
// Package with shared types, constants and lookup functions of the decoder.
package dhd_pkg;

    localparam int BOX_CHANNELS = 5;
    localparam int OBJ_CHANNEL  = 4;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD   = 2'd2;

    typedef struct packed {
        logic signed [7:0] score;
        logic              frame_start;
    } in_word_t;

    typedef struct packed {
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [2:0] anchor_index;
        logic [4:0] class_id;
        logic [6:0] confidence_percent;
    } out_word_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic take_in;
        logic sum_clear;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_class;
        logic detect;
        logic sum_done;
        logic div_done;
    } dp_status_t;

    // exp(-d) in Q1.16, zero for d of 12 and above.
    function automatic logic [16:0] exp_q16(input logic [8:0] d);
        logic [16:0] r;
        begin
            unique case (d)
                9'd0:    r = 17'd65536;
                9'd1:    r = 17'd24109;
                9'd2:    r = 17'd8869;
                9'd3:    r = 17'd3263;
                9'd4:    r = 17'd1200;
                9'd5:    r = 17'd442;
                9'd6:    r = 17'd162;
                9'd7:    r = 17'd60;
                9'd8:    r = 17'd22;
                9'd9:    r = 17'd8;
                9'd10:   r = 17'd3;
                9'd11:   r = 17'd1;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

    // Logistic function in Q0.16, saturated.
    function automatic logic [15:0] sig_q16(input logic signed [7:0] v);
        logic [15:0] r;
        begin
            unique case (v)
                8'sd0:   r = 16'd32768;
                8'sd1:   r = 16'd47911;
                8'sd2:   r = 16'd57724;
                8'sd3:   r = 16'd62428;
                8'sd4:   r = 16'd64357;
                8'sd5:   r = 16'd65097;
                8'sd6:   r = 16'd65374;
                8'sd7:   r = 16'd65476;
                8'sd8:   r = 16'd65514;
                8'sd9:   r = 16'd65528;
                8'sd10:  r = 16'd65533;
                -8'sd1:  r = 16'd17625;
                -8'sd2:  r = 16'd7812;
                -8'sd3:  r = 16'd3108;
                -8'sd4:  r = 16'd1179;
                -8'sd5:  r = 16'd439;
                -8'sd6:  r = 16'd162;
                -8'sd7:  r = 16'd60;
                -8'sd8:  r = 16'd22;
                -8'sd9:  r = 16'd8;
                -8'sd10: r = 16'd3;
                -8'sd11: r = 16'd1;
                default: r = (v > 8'sd0) ? 16'd65535 : 16'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== design/dhd_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module dhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/dhd_datapath.sv =====
// Datapath: position counters, class buffer, exp sum and restoring divider.
module dhd_datapath #(
    parameter int CLASSES  = 20,
    parameter int ANCHORS  = 5,
    parameter int MAX_GRID = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dhd_pkg::dp_cmd_t   cmd,
    output dhd_pkg::dp_status_t status,
    input  dhd_pkg::in_word_t  in_word,
    input  logic [5:0]         grid_width,
    input  logic [5:0]         grid_height,
    input  logic signed [7:0]  threshold,
    output dhd_pkg::out_word_t out_word
);
    localparam int CW = $clog2(dhd_pkg::BOX_CHANNELS + CLASSES);
    localparam int IW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int AW = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
    localparam logic [CW-1:0] LAST_CH = CW'(dhd_pkg::BOX_CHANNELS + CLASSES - 1);
    localparam logic [CW-1:0] OBJ_CH  = CW'(dhd_pkg::OBJ_CHANNEL);
    localparam logic [CW-1:0] FIRST_CLASS = CW'(dhd_pkg::BOX_CHANNELS);
    localparam logic [IW-1:0] LAST_IDX = IW'(CLASSES - 1);
    localparam logic [AW-1:0] LAST_ANCHOR = AW'(ANCHORS - 1);
    localparam logic [5:0] MAX_G = 6'(MAX_GRID);

    logic [CW-1:0] chan_reg;
    logic [AW-1:0] anchor_reg;
    logic [4:0]    col_reg, row_reg;
    logic signed [7:0] obj_reg, max_reg;
    logic [IW-1:0] max_idx_reg;
    logic [CW-1:0] chan;
    logic [AW-1:0] anchor;
    logic [4:0]    col, row;
    logic [5:0]    gw_eff, gh_eff;
    logic [IW-1:0] cls;
    logic          is_class;

    // Effective grid size, clamped to 1..MAX_GRID.
    always_comb
    begin
        gw_eff = (grid_width == 6'd0) ? 6'd1 : ((grid_width > MAX_G) ? MAX_G : grid_width);
        gh_eff = (grid_height == 6'd0) ? 6'd1 : ((grid_height > MAX_G) ? MAX_G : grid_height);
    end

    // Position after frame start clear.
    always_comb
    begin
        chan   = in_word.frame_start ? '0 : chan_reg;
        anchor = in_word.frame_start ? '0 : anchor_reg;
        col    = in_word.frame_start ? '0 : col_reg;
        row    = in_word.frame_start ? '0 : row_reg;
        is_class = (chan >= FIRST_CLASS);
        cls = IW'(chan - FIRST_CLASS);
    end

    // Snapshot of the item being finished.
    logic [4:0] pos_x_reg, pos_y_reg;
    logic [2:0] pos_a_reg;

    // Counters, objectness and running maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            anchor_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            obj_reg <= '0;
            max_reg <= '0;
            max_idx_reg <= '0;
        end
        else if (cmd.take_in)
        begin
            if (chan == OBJ_CH)
            begin
                obj_reg <= in_word.score;
            end
            if (is_class && (cls == '0 || in_word.score > max_reg))
            begin
                max_reg <= in_word.score;
                max_idx_reg <= cls;
            end
            if (chan >= LAST_CH)
            begin
                chan_reg <= '0;
                if (anchor >= LAST_ANCHOR)
                begin
                    anchor_reg <= '0;
                    if (6'(col) + 6'd1 >= gw_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= (6'(row) + 6'd1 >= gh_eff) ? 5'd0 : row + 5'd1;
                    end
                    else
                    begin
                        col_reg <= col + 5'd1;
                        row_reg <= row;
                    end
                end
                else
                begin
                    anchor_reg <= anchor + AW'(1);
                    col_reg <= col;
                    row_reg <= row;
                end
            end
            else
            begin
                chan_reg <= chan + CW'(1);
                anchor_reg <= anchor;
                col_reg <= col;
                row_reg <= row;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            pos_x_reg <= col;
            pos_y_reg <= row;
            pos_a_reg <= 3'(anchor);
        end
    end

    // Status toward the controller, valid in the cycle an item is offered.
    assign status.last_class = (chan >= LAST_CH);
    assign status.detect = ((chan == OBJ_CH) ? in_word.score : obj_reg) > threshold;

    // Class buffer memory; the exp walk reads it back one entry a cycle.
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_valid_reg;
    logic [IW-1:0] rd_cnt_reg;
    logic [7:0]    rdata;
    logic [22:0]   sum_reg;
    logic          sum_done_reg;

    dhd_ram #(.WIDTH(8), .DEPTH(CLASSES)) u_buf (
        .clk   (clk),
        .we    (cmd.take_in && is_class),
        .waddr (cls),
        .wdata (in_word.score),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    assign rd_idx_next = (rd_idx_reg == LAST_IDX) ? rd_idx_reg : rd_idx_reg + IW'(1);

    // Exp sum walk: each address is issued in the cycle before its accumulate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_cnt_reg <= '0;
            sum_reg <= '0;
            sum_done_reg <= 1'b0;
        end
        else if (cmd.sum_clear)
        begin
            rd_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_cnt_reg <= '0;
            sum_reg <= '0;
            sum_done_reg <= 1'b0;
        end
        else if (cmd.sum_step && !sum_done_reg)
        begin
            rd_idx_reg <= rd_idx_next;
            rd_valid_reg <= 1'b1;
            if (rd_valid_reg)
            begin
                sum_reg <= sum_reg + 23'(dhd_pkg::exp_q16(9'(max_reg) - 9'(signed'(rdata))));
                rd_cnt_reg <= rd_cnt_reg + IW'(1);
                if (rd_cnt_reg == LAST_IDX)
                begin
                    sum_done_reg <= 1'b1;
                end
            end
        end
    end
    assign status.sum_done = sum_done_reg;

    // Restoring divider: 100 * S / E, one quotient bit a cycle.
    localparam int NW = 23;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] rem_reg;
    logic [4:0]    div_cnt_reg;
    logic          div_done_reg;
    logic [NW:0]   rem_shift;
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            rem_reg <= '0;
            div_cnt_reg <= '0;
            div_done_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            num_reg <= 23'(dhd_pkg::sig_q16(obj_reg)) * 23'd100;
            rem_reg <= '0;
            div_cnt_reg <= '0;
            div_done_reg <= 1'b0;
        end
        else if (cmd.div_step && !div_done_reg)
        begin
            if (rem_shift >= {1'b0, sum_reg})
            begin
                rem_reg <= NW'(rem_shift - {1'b0, sum_reg});
                num_reg <= {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= NW'(rem_shift);
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (div_cnt_reg == 5'(NW - 1))
            begin
                div_done_reg <= 1'b1;
            end
        end
    end
    assign status.div_done = div_done_reg;

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_word.cell_x <= pos_x_reg;
            out_word.cell_y <= pos_y_reg;
            out_word.anchor_index <= pos_a_reg;
            out_word.class_id <= 5'(max_idx_reg);
            out_word.confidence_percent <= num_reg[6:0];
        end
    end

    `include "detection_head_decoder_top_assert.svh"
    `DHD_ASSERT_NEXT(a_sum_floor, clk, rst_n, sum_done_reg && !cmd.sum_clear, sum_reg >= 23'd65536, "exp sum below one")
    `DHD_ASSERT_NEXT(a_div_hold, clk, rst_n, div_done_reg && !cmd.div_start, div_done_reg, "divider done dropped")
    `DHD_ASSERT_IMPL(a_chan_range, clk, rst_n, chan_reg <= LAST_CH, "channel counter out of range")
endmodule

// ===== design/dhd_ctrl.sv =====
// Controller: accepts words and sequences the exp sum and division.
module dhd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output dhd_pkg::dp_cmd_t    cmd,
    input  dhd_pkg::dp_status_t status
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        cmd.take_in = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.sum_clear = 1'b1;
                if (accept && status.last_class && status.detect)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `include "detection_head_decoder_top_assert.svh"
    `DHD_ASSERT_IMPL(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `DHD_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid_reg, "loaded result not shown")
    `DHD_ASSERT_IMPL(a_no_take_busy, clk, rst_n, !(cmd.take_in && state_reg != S_IDLE), "word taken while busy")
endmodule

// ===== design/detection_head_decoder_top.sv =====
// Top level of the detection head decoder.
//
//  channel   signals                       direction
//  in        in_valid, in_ready, in_data    input word (score, frame_start)
//  out       out_valid, out_ready, out_data detection word
//  cfg       cfg_we, cfg_index, cfg_data    register writes
//
// A word without a detection leaves the controller idle and ready for the next
// word. A detecting word holds the input for the exp sum walk over the class
// buffer, the bit-serial divider (23 quotient bits) and the load of the output
// register.
// Reset is asynchronous and clears counters, state and configuration registers to their defaults.
// A stalled output register holds its word; a following detection then waits
// in the load state, and the input waits with it.
module detection_head_decoder_top #(
    parameter int CLASSES  = 20,
    parameter int ANCHORS  = 5,
    parameter int MAX_GRID = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dhd_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dhd_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    logic [5:0]        gw_reg, gh_reg;
    logic signed [7:0] thr_reg;
    dhd_pkg::dp_cmd_t    cmd;
    dhd_pkg::dp_status_t status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= 6'd13;
            gh_reg <= 6'd13;
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dhd_pkg::REG_GRID_WIDTH:  gw_reg <= cfg_data[5:0];
                dhd_pkg::REG_GRID_HEIGHT: gh_reg <= cfg_data[5:0];
                dhd_pkg::REG_THRESHOLD:   thr_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    dhd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    dhd_datapath #(.CLASSES(CLASSES), .ANCHORS(ANCHORS), .MAX_GRID(MAX_GRID)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_word     (in_data),
        .grid_width  (gw_reg),
        .grid_height (gh_reg),
        .threshold   (thr_reg),
        .out_word    (out_data)
    );
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the detection head decoder top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASS_TOTAL  = 20;
    localparam int ANCHOR_TOTAL = 5;
    localparam int GRID_MAX     = 32;
    localparam int ANCHOR_LEN   = dhd_pkg::BOX_CHANNELS + CLASS_TOTAL;
    localparam int STALL_LIMIT  = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    dhd_pkg::in_word_t  in_data;
    logic       out_valid;
    logic       out_ready;
    dhd_pkg::out_word_t out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Idle and stall rates in percent.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Predictor state.
    logic [5:0]        grid_w_reg;
    logic [5:0]        grid_h_reg;
    logic signed [7:0] thresh_reg;
    logic signed [7:0] class_scores [CLASS_TOTAL];
    int unsigned       chan_cnt;
    int unsigned       anchor_cnt;
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    logic signed [7:0] obj_raw;
    logic signed [7:0] best_score;
    int unsigned       best_idx;

    dhd_pkg::out_word_t pending_detections [$];
    int unsigned error_count;
    int unsigned detection_count;
    int unsigned words_sent;
    int unsigned quiet_cycles;

    detection_head_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Logistic lookup in Q0.16.
    function automatic int unsigned sigmoid_q16(input int v);
        int unsigned pos_tab [12] = '{32768, 47911, 57724, 62428, 64357, 65097,
                                      65374, 65476, 65514, 65528, 65533, 65535};
        int unsigned neg_tab [12] = '{32768, 17625, 7812, 3108, 1179, 439,
                                      162, 60, 22, 8, 3, 1};
        if (v >= 11)
            return 65535;
        if (v <= -12)
            return 0;
        if (v >= 0)
            return pos_tab[v];
        return neg_tab[-v];
    endfunction

    // exp(-d) lookup in Q1.16.
    function automatic int unsigned decay_q16(input int d);
        int unsigned tab [12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                  162, 60, 22, 8, 3, 1};
        if (d < 0 || d >= 12)
            return 0;
        return tab[d];
    endfunction

    function automatic int unsigned grid_limit(input logic [5:0] v);
        if (v == 0)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return v;
    endfunction

    // Advance the decoder model by one word and queue any detection.
    task automatic predict_word(input dhd_pkg::in_word_t w);
        int unsigned sum;
        int unsigned conf;
        int unsigned c;
        dhd_pkg::out_word_t det;
        if (w.frame_start)
        begin
            chan_cnt = 0;
            anchor_cnt = 0;
            col_cnt = 0;
            row_cnt = 0;
        end
        if (chan_cnt == dhd_pkg::OBJ_CHANNEL)
            obj_raw = w.score;
        else if (chan_cnt >= dhd_pkg::BOX_CHANNELS)
        begin
            c = chan_cnt - dhd_pkg::BOX_CHANNELS;
            class_scores[c] = w.score;
            if (c == 0 || w.score > best_score)
            begin
                best_score = w.score;
                best_idx = c;
            end
        end
        if (chan_cnt >= ANCHOR_LEN - 1)
        begin
            if (obj_raw > thresh_reg)
            begin
                sum = 0;
                for (int i = 0; i < CLASS_TOTAL; i++)
                    sum += decay_q16(int'(best_score) - int'(class_scores[i]));
                if (sum == 0)
                    sum = 1;
                conf = (100 * sigmoid_q16(obj_raw)) / sum;
                det.cell_x = col_cnt[4:0];
                det.cell_y = row_cnt[4:0];
                det.anchor_index = anchor_cnt[2:0];
                det.class_id = best_idx[4:0];
                det.confidence_percent = conf[6:0];
                pending_detections.push_back(det);
            end
            chan_cnt = 0;
            anchor_cnt++;
            if (anchor_cnt >= ANCHOR_TOTAL)
            begin
                anchor_cnt = 0;
                col_cnt++;
                if (col_cnt >= grid_limit(grid_w_reg))
                begin
                    col_cnt = 0;
                    row_cnt++;
                    if (row_cnt >= grid_limit(grid_h_reg))
                        row_cnt = 0;
                end
            end
        end
        else
            chan_cnt++;
    endtask

    // Send one word, honoring the idle rate. Valid stays up after the word is
    // taken; the next word, an idle cycle or the drain lowers or reloads it.
    task automatic send_word(input logic signed [7:0] score, input logic start);
        dhd_pkg::in_word_t w;
        w.score = score;
        w.frame_start = start;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    // Send one anchor: box values, objectness, then class scores.
    task automatic send_anchor(input logic start, input logic signed [7:0] obj,
                               input int mode);
        logic signed [7:0] s;
        for (int ch = 0; ch < ANCHOR_LEN; ch++)
        begin
            if (ch == dhd_pkg::OBJ_CHANNEL)
                s = obj;
            else if (ch < dhd_pkg::BOX_CHANNELS)
                s = $urandom;
            else if (mode == 1)
                s = 8'sd127;
            else if (mode == 2)
                s = -8'sd128;
            else if (mode == 3)
                s = $urandom_range(3) - 2;
            else
                s = $urandom;
            send_word(s, start && ch == 0);
        end
    endtask

    // Wait until every detection has arrived, then let the block settle.
    task automatic drain();
        int unsigned guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_detections.size() != 0 && guard < STALL_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == dhd_pkg::REG_GRID_WIDTH)
            grid_w_reg = val[5:0];
        else if (idx == dhd_pkg::REG_GRID_HEIGHT)
            grid_h_reg = val[5:0];
        else if (idx == dhd_pkg::REG_THRESHOLD)
            thresh_reg = val;
        @(negedge clk);
    endtask

    // Extremes of scores, ties, threshold edges and grid wrap.
    task automatic test_directed();
        write_reg(dhd_pkg::REG_GRID_WIDTH, 8'd1);
        write_reg(dhd_pkg::REG_GRID_HEIGHT, 8'd1);
        write_reg(dhd_pkg::REG_THRESHOLD, 8'h80);
        send_anchor(1'b1, 8'sd127, 1);
        send_anchor(1'b0, -8'sd127, 2);
        send_anchor(1'b0, -8'sd128, 0);
        send_anchor(1'b0, 8'sd0, 3);
        send_anchor(1'b0, 8'sd11, 0);
        send_anchor(1'b0, -8'sd12, 0);
        drain();
        write_reg(dhd_pkg::REG_THRESHOLD, 8'h7f);
        send_anchor(1'b1, 8'sd127, 0);
        drain();
    endtask

    // Random frames under the current grid and threshold settings.
    task automatic test_random_frames(input int anchors);
        for (int a = 0; a < anchors; a++)
            send_anchor(a == 0 || $urandom_range(19) == 0,
                        $urandom_range(99) < 70 ? $urandom_range(24) - 12 : $urandom,
                        $urandom_range(4));
        drain();
    endtask

    // Words that break an anchor with a fresh frame start.
    task automatic test_broken_frames();
        for (int k = 0; k < 40; k++)
            send_word($urandom, $urandom_range(3) == 0);
        send_anchor(1'b1, 8'sd5, 0);
        drain();
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input logic [7:0] gw, input logic [7:0] gh,
                             input logic [7:0] th);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_reg(dhd_pkg::REG_GRID_WIDTH, gw);
        write_reg(dhd_pkg::REG_GRID_HEIGHT, gh);
        write_reg(dhd_pkg::REG_THRESHOLD, th);
        test_random_frames(7);
    endtask

    // Receiver stall generator.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker.
    always @(posedge clk)
    begin
        dhd_pkg::out_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_detections.size() == 0)
            begin
                $display("%0t: unexpected detection %h", $time, out_data);
                error_count++;
            end
            else
            begin
                exp_w = pending_detections.pop_front();
                detection_count++;
                if (out_data !== exp_w)
                begin
                    $display("%0t: mismatch expected x=%0d y=%0d a=%0d c=%0d p=%0d",
                             $time, exp_w.cell_x, exp_w.cell_y, exp_w.anchor_index,
                             exp_w.class_id, exp_w.confidence_percent);
                    $display("%0t:          actual   x=%0d y=%0d a=%0d c=%0d p=%0d",
                             $time, out_data.cell_x, out_data.cell_y,
                             out_data.anchor_index, out_data.class_id,
                             out_data.confidence_percent);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on accepted words and delivered detections.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        detection_count = 0;
        words_sent = 0;
        grid_w_reg = 6'd13;
        grid_h_reg = 6'd13;
        thresh_reg = 8'sd0;
        chan_cnt = 0;
        anchor_cnt = 0;
        col_cnt = 0;
        row_cnt = 0;
        obj_raw = 0;
        best_score = 0;
        best_idx = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_broken_frames();
        run_phase(0, 0, 8'd2, 8'd3, 8'd0);
        run_phase(86, 0, 8'd0, 8'd0, 8'hfe);
        run_phase(0, 86, 8'd63, 8'd40, 8'd3);
        run_phase(20, 20, 8'd32, 8'd32, 8'h80);
        run_phase(0, 0, 8'd1, 8'd2, 8'd1);
        run_phase(20, 20, 8'd3, 8'd1, 8'hfb);
        drain();

        $display("Sent %0d words across six grid and threshold settings.", words_sent);
        $display("Checked %0d detections under varied idle and stall rates.",
                 detection_count);
        if (error_count == 0 && pending_detections.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
